@@ src/dfatsa_pkg.sv @@
// Shared types, constants and helpers for the table-driven DFA stream acceptor.
// No dependencies; every other file of the block imports this package.
package dfatsa_pkg;

  localparam int unsigned STATE_BITS = 6;
  localparam int unsigned SYM_BITS   = 8;
  localparam int unsigned COUNT_BITS = STATE_BITS + 1;
  localparam int unsigned NUM_STATES = 1 << STATE_BITS;
  localparam int unsigned ADDR_BITS  = STATE_BITS + SYM_BITS;
  localparam int unsigned DEPTH      = 1 << ADDR_BITS;
  localparam int unsigned CFG_BITS   = NUM_STATES;

  typedef logic [STATE_BITS-1:0] state_t;
  typedef logic [SYM_BITS-1:0]   sym_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_SYMBOL  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_BAD_STATE = 2'd2,
    ST_NO_START  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_STATE_COUNT    = 2'd0,
    CFG_START_STATE    = 2'd1,
    CFG_START_ENABLE   = 2'd2,
    CFG_ACCEPTING_MASK = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    count_t                state_count;
    state_t                start_state;
    logic                  start_enable;
    logic [NUM_STATES-1:0] accepting_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    state_t     from_state;
    state_t     to_state;
    sym_t       symbol;
    logic       last;
  } in_item_t;

  typedef struct packed {
    status_e status;
    state_t  current_state;
    state_t  following_state;
    logic    dead;
    logic    verdict_valid;
    logic    accept;
  } out_item_t;

  // One word of the transition store: presence flag and target state
  typedef struct packed {
    logic   valid;
    state_t next;
  } entry_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    entry_t data;
  } mem_wr_t;

  // Run context carried from one symbol to the next
  typedef struct packed {
    logic   mid;
    logic   dead;
    state_t state;
  } run_ctx_t;

  // Values of state_count above NUM_STATES behave as NUM_STATES
  function automatic logic state_ok(state_t s, count_t n);
    return {1'b0, s} < n;
  endfunction

  function automatic addr_t slot(state_t s, sym_t y);
    return {s, y};
  endfunction

endpackage

@@ src/dfatsa_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on dfatsa_pkg for the field types.
interface dfatsa_in_if;
  import dfatsa_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] action;
  state_t     from_state;
  state_t     to_state;
  sym_t       symbol;
  logic       last;

  modport source (output valid, output action, output from_state, output to_state,
                  output symbol, output last, input ready);
  modport sink   (input valid, input action, input from_state, input to_state,
                  input symbol, input last, output ready);
endinterface

interface dfatsa_out_if;
  import dfatsa_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] status;
  state_t     current_state;
  state_t     following_state;
  logic       dead;
  logic       verdict_valid;
  logic       accept;

  modport source (output valid, output status, output current_state,
                  output following_state, output dead, output verdict_valid,
                  output accept, input ready);
  modport sink   (input valid, input status, input current_state,
                  input following_state, input dead, input verdict_valid,
                  input accept, output ready);
endinterface

@@ src/dfatsa_mem.sv @@
// Transition store: single-port-write, registered-read memory plus the
// clearing sweep that runs after reset. Depends on dfatsa_pkg.
module dfatsa_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  dfatsa_pkg::addr_t   rd_addr_i,
  output dfatsa_pkg::entry_t  rd_data_o,
  input  dfatsa_pkg::mem_wr_t wr_i,
  output logic                clearing_o
);
  import dfatsa_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;
  logic   clr_q;
  addr_t  clr_cnt_q;
  logic   we;
  addr_t  wa;
  entry_t wd;

  // sweep owns the write port until every entry holds an empty word
  always_comb begin
    if (clr_q) begin
      we = 1'b1;
      wa = clr_cnt_q;
      wd = '0;
    end else begin
      we = wr_i.en;
      wa = wr_i.addr;
      wd = wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clr_q;

endmodule

@@ src/dfatsa_pipe.sv @@
// Two-stage lookup pipeline: address issue with run-context forwarding,
// then check, update and write-back of the transition store. Depends on dfatsa_pkg.
module dfatsa_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dfatsa_pkg::cfg_t      cfg_i,
  input  logic                  clearing_i,
  input  logic                  item_valid_i,
  input  dfatsa_pkg::in_item_t  item_i,
  output logic                  item_ready_o,
  output logic                  res_valid_o,
  output dfatsa_pkg::out_item_t res_o,
  input  logic                  res_ready_i,
  output logic                  rd_en_o,
  output dfatsa_pkg::addr_t     rd_addr_o,
  input  dfatsa_pkg::entry_t    rd_data_i,
  output dfatsa_pkg::mem_wr_t   wr_o
);
  import dfatsa_pkg::*;

  // second stage
  logic       b_valid_q;
  logic [1:0] b_action_q;
  state_t     b_from_q;
  state_t     b_to_q;
  logic       b_last_q;
  addr_t      b_addr_q;
  state_t     b_cur_q;
  logic       b_dead_in_q;
  logic       b_no_start_q;
  run_ctx_t   b_pre_q;
  logic       b_fwd_q;
  state_t     b_fwd_data_q;
  run_ctx_t   run_q;

  logic      accept;
  logic      b_adv;
  logic      start_ok;
  entry_t    entry_eff;
  logic      hit;
  logic      dead_out;
  state_t    nstate;
  logic      write_ok;
  run_ctx_t  b_post;
  out_item_t b_out;

  run_ctx_t pre_a;
  state_t   a_state;
  logic     a_dead;
  logic     a_no_start;
  addr_t    a_addr;
  logic     a_fwd;

  assign start_ok = cfg_i.start_enable && state_ok(cfg_i.start_state, cfg_i.state_count);
  assign b_adv    = b_valid_q && res_ready_i;
  assign item_ready_o = !clearing_i && (!b_valid_q || b_adv);
  assign accept   = item_valid_i && item_ready_o;

  // a write issued ahead of us to the same entry overrides the stale read
  always_comb begin
    if (b_fwd_q) begin
      entry_eff.valid = 1'b1;
      entry_eff.next  = b_fwd_data_q;
    end else begin
      entry_eff = rd_data_i;
    end
  end

  assign hit = !b_dead_in_q && entry_eff.valid && state_ok(b_cur_q, cfg_i.state_count)
               && state_ok(entry_eff.next, cfg_i.state_count);
  assign dead_out = !hit;
  assign nstate   = hit ? entry_eff.next : b_cur_q;

  // second stage: result and run context after the transaction
  always_comb begin
    b_out    = '0;
    b_post   = b_pre_q;
    write_ok = 1'b0;
    case (b_action_q)
      ACT_WRITE: begin
        if (!state_ok(b_from_q, cfg_i.state_count) || !state_ok(b_to_q, cfg_i.state_count)) begin
          b_out.status = ST_BAD_STATE;
        end else if (entry_eff.valid) begin
          b_out.status = ST_DUP;
        end else begin
          write_ok = 1'b1;
        end
      end
      ACT_RESTART: begin
        b_out.verdict_valid = 1'b1;
        b_post = '{mid: 1'b0, dead: 1'b0, state: cfg_i.start_state};
        if (!start_ok) begin
          b_out.status = ST_NO_START;
          b_out.dead   = 1'b1;
        end else begin
          b_out.current_state   = cfg_i.start_state;
          b_out.following_state = cfg_i.start_state;
          b_out.accept          = cfg_i.accepting_mask[cfg_i.start_state];
        end
      end
      ACT_SYMBOL: begin
        b_out.status          = b_no_start_q ? ST_NO_START : ST_OK;
        b_out.current_state   = b_cur_q;
        b_out.following_state = hit ? entry_eff.next : '0;
        b_out.dead            = dead_out;
        if (b_last_q) begin
          b_out.verdict_valid = 1'b1;
          b_out.accept        = !dead_out && cfg_i.accepting_mask[nstate];
          b_post = '{mid: 1'b0, dead: 1'b0, state: cfg_i.start_state};
        end else begin
          b_post = '{mid: 1'b1, dead: dead_out, state: nstate};
        end
      end
      default: begin
        b_out = '0;
      end
    endcase
  end

  assign wr_o.en         = b_adv && write_ok;
  assign wr_o.addr       = b_addr_q;
  assign wr_o.data.valid = 1'b1;
  assign wr_o.data.next  = b_to_q;

  // first stage: take the context straight from the stage ahead when occupied
  assign pre_a = b_valid_q ? b_post : run_q;

  always_comb begin
    if (!pre_a.mid) begin
      a_no_start = !start_ok;
      a_dead     = !start_ok;
      a_state    = start_ok ? cfg_i.start_state : '0;
    end else begin
      a_no_start = 1'b0;
      a_dead     = pre_a.dead;
      a_state    = pre_a.state;
    end
  end

  assign a_addr = (item_i.action == ACT_WRITE) ? slot(item_i.from_state, item_i.symbol)
                                               : slot(a_state, item_i.symbol);
  assign a_fwd  = wr_o.en && (wr_o.addr == a_addr);

  assign rd_en_o   = accept;
  assign rd_addr_o = a_addr;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_action_q   <= item_i.action;
      b_from_q     <= item_i.from_state;
      b_to_q       <= item_i.to_state;
      b_last_q     <= item_i.last;
      b_addr_q     <= a_addr;
      b_cur_q      <= a_state;
      b_dead_in_q  <= a_dead;
      b_no_start_q <= a_no_start;
      b_pre_q      <= pre_a;
      b_fwd_q      <= a_fwd;
      b_fwd_data_q <= b_to_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      run_q     <= '0;
    end else begin
      if (accept) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        run_q <= b_post;
      end
    end
  end

  assign res_valid_o = b_valid_q;
  assign res_o       = b_out;

endmodule

@@ src/dfatsa_top_regs.sv @@
// Configuration register file of the DFA acceptor, written through a plain
// index/data write port. Depends on dfatsa_pkg.
module dfatsa_top_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [dfatsa_pkg::CFG_BITS-1:0] cfg_data_i,
  output dfatsa_pkg::cfg_t               cfg_o
);
  import dfatsa_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.state_count    <= count_t'(1);
      cfg_q.start_state    <= '0;
      cfg_q.start_enable   <= 1'b0;
      cfg_q.accepting_mask <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STATE_COUNT:    cfg_q.state_count    <= cfg_data_i[COUNT_BITS-1:0];
        CFG_START_STATE:    cfg_q.start_state    <= cfg_data_i[STATE_BITS-1:0];
        CFG_START_ENABLE:   cfg_q.start_enable   <= cfg_data_i[0];
        CFG_ACCEPTING_MASK: cfg_q.accepting_mask <= cfg_data_i[NUM_STATES-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/dfa_table_stream_acceptor_unit.sv @@
// Table-driven DFA stream acceptor: top level with the result output register.
// Depends on dfatsa_pkg, dfatsa_if, dfatsa_mem, dfatsa_pipe and dfatsa_top_regs.
// Path: second pipeline stage register, then the output register.
// Throughput: one transaction per cycle unless the output stalls; the store read data
//   feeds the next lookup address in the same cycle, so symbols never wait on lookups.
// Reset: registers clear at once, then a sweep writes an empty word to all 16384
//   store entries; input ready stays low until it ends (config writes go on).
module dfa_table_stream_acceptor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dfatsa_in_if.sink                       in_i,
  dfatsa_out_if.source                    out_o,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [dfatsa_pkg::CFG_BITS-1:0] cfg_data_i
);
  import dfatsa_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  logic      item_ready;
  logic      res_valid;
  out_item_t res;
  logic      res_ready;
  logic      rd_en;
  addr_t     rd_addr;
  entry_t    rd_data;
  mem_wr_t   wr;
  logic      clearing;

  logic      out_valid_q;
  out_item_t out_q;

  dfatsa_top_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // gather the input payload into one word
  assign item.action     = in_i.action;
  assign item.from_state = in_i.from_state;
  assign item.to_state   = in_i.to_state;
  assign item.symbol     = in_i.symbol;
  assign item.last       = in_i.last;
  assign in_i.ready      = item_ready;

  // lookup/update pipeline; the transition store sits beside it
  dfatsa_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .clearing_i   (clearing),
    .item_valid_i (in_i.valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_o         (wr)
  );

  dfatsa_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_i       (wr),
    .clearing_o (clearing)
  );

  // output register: refill whenever empty or being drained this cycle;
  // the pipeline stalls only while a held result is not taken
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // payload needs no reset; hold it while the sink stalls
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_q.status;
  assign out_o.current_state   = out_q.current_state;
  assign out_o.following_state = out_q.following_state;
  assign out_o.dead            = out_q.dead;
  assign out_o.verdict_valid   = out_q.verdict_valid;
  assign out_o.accept          = out_q.accept;

endmodule
